// ----- sv/gsc_pkg.sv -----
// shared types and constants for the gamepad sample conditioner
`timescale 1ns / 1ps
`default_nettype none

package gsc_pkg;

    // configuration register indexes
    localparam logic CFG_DEADZONE = 1'b0;
    localparam logic CFG_ENABLE   = 1'b1;

    localparam logic [6:0] DZ_MAX   = 7'd64;
    localparam logic [6:0] DZ_RESET = 7'd10;

    // operands run through the shared divider, in this order
    localparam int unsigned OP_W = 3;
    localparam logic [OP_W-1:0] OP_LX = 3'd0;
    localparam logic [OP_W-1:0] OP_LY = 3'd1;
    localparam logic [OP_W-1:0] OP_RX = 3'd2;
    localparam logic [OP_W-1:0] OP_RY = 3'd3;
    localparam logic [OP_W-1:0] OP_LT = 3'd4;
    localparam logic [OP_W-1:0] OP_RT = 3'd5;
    localparam int unsigned NUM_OPS = 6;

    // held-button bits standing in for digital triggers
    localparam int unsigned BTN_LT = 8;
    localparam int unsigned BTN_RT = 9;

    typedef struct packed {
        logic            capture;
        logic            load;
        logic            step;
        logic            store;
        logic            publish;
        logic [OP_W-1:0] op;
    } t_dp_cmd;

    typedef struct packed {
        logic live;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- sv/gamepad_sample_conditioner_core.sv -----
// top level of the gamepad sample conditioner
`timescale 1ns / 1ps
`default_nettype none

// one transfer on the input channel is one controller poll for one port; one
// transfer on the output channel follows for every poll. a live poll (block
// enabled, port in range, pad ready and read ok) gives active-high held
// buttons, pressed and released masks against that port's previous live poll,
// four stick axes with dead band applied and scaled to signed fixed point with
// FRAC_BITS fraction bits, clamped to plus or minus one, and two trigger
// levels in the same scale (analog on a pressure pad, button bits 8 and 9
// otherwise). any other poll yields an all-zero result; a poll to an enabled
// block and in-range port that fails the ready or read check also clears
// that port's button history. one shared restoring divider, producing two
// quotient bits a cycle, is visited once per axis and trigger on a live poll.
// the finished result sits in an output register, so a new poll is accepted
// while the previous result still waits to be taken. config writes are
// accepted every cycle (index 0 dead zone, saturating at 64; index 1 enable)
// and must be issued only while no poll is in flight.
module gamepad_sample_conditioner_core
    import gsc_pkg::*;
#(
    parameter int NUM_PORTS = 2,
    parameter int FRAC_BITS = 14
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // config write channel
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic               i_cfg_index,
    input  wire logic [6:0]         i_cfg_data,
    // poll channel
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_port,
    input  wire logic               i_pad_ready,
    input  wire logic               i_read_ok,
    input  wire logic [15:0]        i_buttons_raw,
    input  wire logic [7:0]         i_left_x_raw,
    input  wire logic [7:0]         i_left_y_raw,
    input  wire logic [7:0]         i_right_x_raw,
    input  wire logic [7:0]         i_right_y_raw,
    input  wire logic [7:0]         i_left_trigger_raw,
    input  wire logic [7:0]         i_right_trigger_raw,
    input  wire logic               i_pressure_pad,
    // result channel
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic                    o_connected,
    output logic [15:0]             o_held,
    output logic [15:0]             o_pressed,
    output logic [15:0]             o_released,
    output logic signed [15:0]      o_left_x,
    output logic signed [15:0]      o_left_y,
    output logic signed [15:0]      o_right_x,
    output logic signed [15:0]      o_right_y,
    output logic [14:0]             o_left_trigger,
    output logic [14:0]             o_right_trigger
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // config registers never stall
    assign o_cfg_ready = 1'b1;

    // sequencer: capture, per-operand load / divide / store, publish
    gsc_controller #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid)
    );

    // registers, history, divider and result hold
    gsc_datapath #(
        .NUM_PORTS (NUM_PORTS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_port              (i_port),
        .i_pad_ready         (i_pad_ready),
        .i_read_ok           (i_read_ok),
        .i_buttons_raw       (i_buttons_raw),
        .i_left_x_raw        (i_left_x_raw),
        .i_left_y_raw        (i_left_y_raw),
        .i_right_x_raw       (i_right_x_raw),
        .i_right_y_raw       (i_right_y_raw),
        .i_left_trigger_raw  (i_left_trigger_raw),
        .i_right_trigger_raw (i_right_trigger_raw),
        .i_pressure_pad      (i_pressure_pad),
        .i_cmd               (cmd),
        .o_status            (status),
        .o_connected         (o_connected),
        .o_held              (o_held),
        .o_pressed           (o_pressed),
        .o_released          (o_released),
        .o_left_x            (o_left_x),
        .o_left_y            (o_left_y),
        .o_right_x           (o_right_x),
        .o_right_y           (o_right_y),
        .o_left_trigger      (o_left_trigger),
        .o_right_trigger     (o_right_trigger)
    );

endmodule

`default_nettype wire

// ----- sv/gsc_datapath.sv -----
// datapath: config registers, button history, shared divider, result registers
`timescale 1ns / 1ps
`default_nettype none

module gsc_datapath
    import gsc_pkg::*;
#(
    parameter int NUM_PORTS = 2,
    parameter int FRAC_BITS = 14
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    input  wire logic               i_cfg_index,
    input  wire logic [6:0]         i_cfg_data,
    input  wire logic               i_port,
    input  wire logic               i_pad_ready,
    input  wire logic               i_read_ok,
    input  wire logic [15:0]        i_buttons_raw,
    input  wire logic [7:0]         i_left_x_raw,
    input  wire logic [7:0]         i_left_y_raw,
    input  wire logic [7:0]         i_right_x_raw,
    input  wire logic [7:0]         i_right_y_raw,
    input  wire logic [7:0]         i_left_trigger_raw,
    input  wire logic [7:0]         i_right_trigger_raw,
    input  wire logic               i_pressure_pad,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_status              o_status,
    output logic                    o_connected,
    output logic [15:0]             o_held,
    output logic [15:0]             o_pressed,
    output logic [15:0]             o_released,
    output logic signed [15:0]      o_left_x,
    output logic signed [15:0]      o_left_y,
    output logic signed [15:0]      o_right_x,
    output logic signed [15:0]      o_right_y,
    output logic [14:0]             o_left_trigger,
    output logic [14:0]             o_right_trigger
);

    localparam int PW  = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int PRE = (FRAC_BITS % 2 == 0) ? 2 : 3;
    localparam int S   = FRAC_BITS + PRE;
    localparam int RW  = (FRAC_BITS + 2 > 16) ? FRAC_BITS + 2 : 16;
    localparam logic [S-1:0] ONE_S = S'(1) << FRAC_BITS;

    // config
    logic [6:0]  r_deadzone;
    logic        r_enabled;

    // per-port button history
    logic [15:0] r_prev [NUM_PORTS];

    // captured poll
    logic [7:0]  r_raw [NUM_OPS];
    logic        r_pad;
    logic        r_live;
    logic        r_held;
    logic [15:0] r_held_w;
    logic [15:0] r_pressed_w;
    logic [15:0] r_released_w;
    logic [15:0] r_res [NUM_OPS];

    // divider
    logic [7:0]   r_rem;
    logic [7:0]   r_div;
    logic [S-1:0] r_num;
    logic [S-1:0] r_quo;
    logic         r_neg;

    // output register
    logic        r_o_conn;
    logic [15:0] r_o_held;
    logic [15:0] r_o_pressed;
    logic [15:0] r_o_released;
    logic [15:0] r_o_res [NUM_OPS];

    logic          port_ok;
    logic [PW-1:0] pidx;
    logic          live;
    logic [15:0]   held_n;
    logic [15:0]   prev;
    logic [7:0]    raw;
    logic [7:0]    d8;
    logic [7:0]    t_lo;
    logic [7:0]    c_hi;
    logic          in_band;
    logic          dig_on;
    logic [7:0]    ld_m;
    logic [7:0]    ld_div;
    logic          ld_neg;
    logic [8:0]    trial1;
    logic [8:0]    trial2;
    logic          ge1;
    logic          ge2;
    logic [7:0]    rem1;
    logic [7:0]    rem2;
    logic [S-1:0]  q_clamp;
    logic [RW-1:0] mag_ext;
    logic [RW-1:0] res_ext;

    always_comb begin
        port_ok = (32'(i_port) < NUM_PORTS);
        pidx    = PW'(i_port);
        live    = r_enabled & port_ok & i_pad_ready & i_read_ok;
        held_n  = ~i_buttons_raw;
        prev    = port_ok ? r_prev[pidx] : 16'd0;
    end

    // operand setup for the divider
    always_comb begin
        raw     = r_raw[i_cmd.op];
        d8      = {1'b0, r_deadzone};
        t_lo    = 8'd128 - raw;
        c_hi    = {1'b0, raw[6:0]};
        dig_on  = (i_cmd.op == OP_LT) ? r_held_w[BTN_LT] : r_held_w[BTN_RT];
        in_band = 1'b0;
        ld_m    = 8'd0;
        ld_div  = 8'd255;
        ld_neg  = 1'b0;
        if (i_cmd.op == OP_LT || i_cmd.op == OP_RT) begin
            ld_m = r_pad ? raw : (dig_on ? 8'd255 : 8'd0);
        end else if (!raw[7]) begin
            // below centre
            in_band = (t_lo < d8);
            ld_m    = in_band ? 8'd0 : (t_lo - d8);
            ld_div  = 8'd128 - d8;
            ld_neg  = 1'b1;
        end else begin
            in_band = (c_hi < d8);
            ld_m    = in_band ? 8'd0 : (c_hi - d8);
            ld_div  = 8'd127 - d8;
        end
    end

    // two restoring steps per cycle
    always_comb begin
        trial1 = {r_rem, r_num[S-1]};
        ge1    = (trial1 >= {1'b0, r_div});
        rem1   = ge1 ? 8'(trial1 - {1'b0, r_div}) : trial1[7:0];
        trial2 = {rem1, r_num[S-2]};
        ge2    = (trial2 >= {1'b0, r_div});
        rem2   = ge2 ? 8'(trial2 - {1'b0, r_div}) : trial2[7:0];
    end

    // clamp, sign and truncate
    always_comb begin
        q_clamp = (r_quo > ONE_S) ? ONE_S : r_quo;
        mag_ext = RW'(q_clamp[FRAC_BITS:0]);
        res_ext = r_neg ? (RW'(0) - mag_ext) : mag_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadzone <= DZ_RESET;
            r_enabled  <= 1'b0;
            r_live     <= 1'b0;
            for (int p = 0; p < NUM_PORTS; p++) begin
                r_prev[p] <= 16'd0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_DEADZONE: begin
                        r_deadzone <= (i_cfg_data > DZ_MAX) ? DZ_MAX : i_cfg_data;
                    end
                    CFG_ENABLE: begin
                        r_enabled <= i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.capture) begin
                r_live <= live;
                if (r_enabled && port_ok) begin
                    r_prev[pidx] <= (i_pad_ready && i_read_ok) ? held_n : 16'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_raw[OP_LX]  <= i_left_x_raw;
            r_raw[OP_LY]  <= i_left_y_raw;
            r_raw[OP_RX]  <= i_right_x_raw;
            r_raw[OP_RY]  <= i_right_y_raw;
            r_raw[OP_LT]  <= i_left_trigger_raw;
            r_raw[OP_RT]  <= i_right_trigger_raw;
            r_pad         <= i_pressure_pad;
            r_held        <= live;
            r_held_w      <= live ? held_n : 16'd0;
            r_pressed_w   <= live ? (held_n & ~prev) : 16'd0;
            r_released_w  <= live ? (prev & ~held_n) : 16'd0;
            for (int k = 0; k < NUM_OPS; k++) begin
                r_res[k] <= 16'd0;
            end
        end
        if (i_cmd.load) begin
            r_rem <= 8'(ld_m >> PRE);
            r_num <= S'(ld_m[PRE-1:0]) << FRAC_BITS;
            r_quo <= '0;
            r_div <= ld_div;
            r_neg <= ld_neg;
        end
        if (i_cmd.step) begin
            r_rem <= rem2;
            r_num <= r_num << 2;
            r_quo <= {r_quo[S-3:0], ge1, ge2};
        end
        if (i_cmd.store) begin
            r_res[i_cmd.op] <= res_ext[15:0];
        end
        if (i_cmd.publish) begin
            r_o_conn     <= r_held;
            r_o_held     <= r_held_w;
            r_o_pressed  <= r_pressed_w;
            r_o_released <= r_released_w;
            for (int k = 0; k < NUM_OPS; k++) begin
                r_o_res[k] <= r_res[k];
            end
        end
    end

    assign o_status.live   = r_live;
    assign o_connected     = r_o_conn;
    assign o_held          = r_o_held;
    assign o_pressed       = r_o_pressed;
    assign o_released      = r_o_released;
    assign o_left_x        = r_o_res[OP_LX];
    assign o_left_y        = r_o_res[OP_LY];
    assign o_right_x       = r_o_res[OP_RX];
    assign o_right_y       = r_o_res[OP_RY];
    assign o_left_trigger  = r_o_res[OP_LT][14:0];
    assign o_right_trigger = r_o_res[OP_RT][14:0];

endmodule

`default_nettype wire

// ----- sv/gsc_controller.sv -----
// controller: sequences capture, the six divisions of a live poll and the result transfer
`timescale 1ns / 1ps
`default_nettype none

module gsc_controller
    import gsc_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_out_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd,
    output logic            o_in_ready,
    output logic            o_out_valid
);

    localparam int PRE  = (FRAC_BITS % 2 == 0) ? 2 : 3;
    localparam int HALF = (FRAC_BITS + PRE) / 2;
    localparam int CW   = $clog2(HALF);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_STORE,
        S_FINISH
    } t_state;

    t_state          r_state, n_state;
    logic [OP_W-1:0] r_op, n_op;
    logic [CW-1:0]   r_step, n_step;
    logic            r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_step      = r_step;
        n_out_valid = r_out_valid & ~i_out_ready;
        o_cmd       = '0;
        o_cmd.op    = r_op;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_op          = OP_LX;
                    n_state       = S_LOAD;
                end
            end
            S_LOAD: begin
                if (i_status.live) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = S_DIV;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                n_step     = r_step + 1'b1;
                if (r_step == CW'(HALF - 1)) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                if (r_op == OP_RT) begin
                    n_state = S_FINISH;
                end else begin
                    n_op    = r_op + 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.publish = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_LX;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- sv/gsc_checker.sv -----
// port-level checks for the gamepad sample conditioner, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module gsc_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic               o_connected,
    input wire logic [15:0]        o_held,
    input wire logic [15:0]        o_pressed,
    input wire logic [15:0]        o_released,
    input wire logic signed [15:0] o_left_x,
    input wire logic signed [15:0] o_left_y,
    input wire logic signed [15:0] o_right_x,
    input wire logic signed [15:0] o_right_y,
    input wire logic [14:0]        o_left_trigger,
    input wire logic [14:0]        o_right_trigger
);

    // a waiting result holds until taken (held buttons, left x and right trigger checked)
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_held) && $stable(o_left_x) && $stable(o_right_trigger))
        else $error("result changed while stalled");

    // one poll at a time
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("poll accepted while busy");

    // a dead poll reports nothing
    a_dead_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_connected |->
            o_held == 16'd0 && o_pressed == 16'd0 && o_released == 16'd0 &&
            o_left_x == 16'sd0 && o_left_y == 16'sd0 && o_right_x == 16'sd0 &&
            o_right_y == 16'sd0 && o_left_trigger == 15'd0 && o_right_trigger == 15'd0)
        else $error("nonzero result on a dead poll");

    // edge masks agree with the held buttons
    a_edge_masks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pressed & ~o_held) == 16'd0 && (o_released & o_held) == 16'd0)
        else $error("pressed or released mask disagrees with held");

endmodule

bind gamepad_sample_conditioner_core gsc_checker u_gsc_checker (.*);

`default_nettype wire
